[src/lru_pr_pkg.sv]
`default_nettype none
package lru_pr_pkg;

	localparam int CFG_W  = 5;
	localparam int SLOT_W = 4;
	localparam int CNT_W  = 32;

	localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd16;
	localparam logic [CNT_W-1:0] CNT_MAX      = 32'hFFFF_FFFF;

	typedef struct packed {
		logic hit;
		logic fill;
		logic evict;
	} lookup_t;

endpackage
`default_nettype wire

[src/lru_pr_req_if.sv]
`default_nettype none
interface lru_pr_req_if #(
	parameter int PAGE_BITS = 16
) ();
	logic                 valid;
	logic                 ready;
	logic                 clear_first;
	logic [PAGE_BITS-1:0] page;

	modport source (output valid, output clear_first, output page, input ready);
	modport sink (input valid, input clear_first, input page, output ready);
endinterface
`default_nettype wire

[src/lru_pr_rsp_if.sv]
`default_nettype none
interface lru_pr_rsp_if #(
	parameter int PAGE_BITS = 16
) ();
	logic                              valid;
	logic                              ready;
	logic                              hit;
	logic [lru_pr_pkg::SLOT_W-1:0]     slot;
	logic                              evicted_valid;
	logic [PAGE_BITS-1:0]              evicted_page;
	logic [lru_pr_pkg::CNT_W-1:0]      fault_count;
	logic [lru_pr_pkg::CNT_W-1:0]      reference_count;

	modport source (
		output valid, output hit, output slot, output evicted_valid,
		output evicted_page, output fault_count, output reference_count,
		input ready
	);
	modport sink (
		input valid, input hit, input slot, input evicted_valid,
		input evicted_page, input fault_count, input reference_count,
		output ready
	);
endinterface
`default_nettype wire

[src/lru_pr_select.sv]
`default_nettype none
module lru_pr_select #(
	parameter int NUM_FRAMES = 16,
	parameter int PAGE_BITS  = 16,
	parameter int IDX_W      = 4
) (
	input  wire logic [NUM_FRAMES-1:0]                valid_eff,
	input  wire logic [NUM_FRAMES-1:0]                active,
	input  wire logic [NUM_FRAMES-1:0][PAGE_BITS-1:0] pages,
	input  wire logic [NUM_FRAMES-1:0][IDX_W-1:0]     rank_eff,
	input  wire logic [PAGE_BITS-1:0]                 page,
	output lru_pr_pkg::lookup_t                       look,
	output logic      [IDX_W-1:0]                     idx
);

	logic [NUM_FRAMES-1:0] match;
	logic [NUM_FRAMES-1:0] free;
	logic [NUM_FRAMES-1:0] oldest;
	logic [NUM_FRAMES-1:0] pick;

	always_comb begin
		for (int i = 0; i < NUM_FRAMES; i++) begin
			match[i]  = active[i] && valid_eff[i] && (pages[i] == page);
			free[i]   = active[i] && !valid_eff[i];
			oldest[i] = active[i];
			for (int j = 0; j < NUM_FRAMES; j++) begin
				if (active[j] && j < i && !(rank_eff[j] < rank_eff[i]))
					oldest[i] = 1'b0;
				if (active[j] && j > i && (rank_eff[j] > rank_eff[i]))
					oldest[i] = 1'b0;
			end
		end
	end

	always_comb begin
		look.hit   = |match;
		look.fill  = !(|match) && (|free);
		look.evict = !(|match) && !(|free);
		if (look.hit)
			pick = match;
		else if (look.fill)
			pick = free;
		else
			pick = oldest;
	end

	// lowest set index wins
	always_comb begin
		idx = '0;
		for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
			if (pick[i])
				idx = IDX_W'(i);
		end
	end

endmodule
`default_nettype wire

[src/lru_pr_frames.sv]
`default_nettype none
module lru_pr_frames #(
	parameter int NUM_FRAMES = 16,
	parameter int PAGE_BITS  = 16,
	parameter int IDX_W      = 4
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 upd,
	input  wire logic                                 clear,
	input  wire logic [PAGE_BITS-1:0]                 page,
	input  wire logic [NUM_FRAMES-1:0]                active,
	input  wire lru_pr_pkg::lookup_t                  look,
	input  wire logic [IDX_W-1:0]                     idx,
	output logic      [NUM_FRAMES-1:0]                valid_eff,
	output logic      [NUM_FRAMES-1:0][IDX_W-1:0]     rank_eff,
	output logic      [NUM_FRAMES-1:0][PAGE_BITS-1:0] pages,
	output logic      [lru_pr_pkg::CNT_W-1:0]         fault_nx,
	output logic      [lru_pr_pkg::CNT_W-1:0]         ref_nx
);

	localparam logic [IDX_W-1:0] RANK_MAX = IDX_W'(NUM_FRAMES - 1);

	logic [NUM_FRAMES-1:0]                valid_q;
	logic [NUM_FRAMES-1:0][IDX_W-1:0]     rank_q;
	logic [NUM_FRAMES-1:0][PAGE_BITS-1:0] page_q;
	logic [lru_pr_pkg::CNT_W-1:0]         fault_q;
	logic [lru_pr_pkg::CNT_W-1:0]         ref_q;

	logic [NUM_FRAMES-1:0]                valid_nx;
	logic [NUM_FRAMES-1:0][IDX_W-1:0]     rank_nx;
	logic [IDX_W-1:0]                     bound;
	logic [lru_pr_pkg::CNT_W-1:0]         fault_base;
	logic [lru_pr_pkg::CNT_W-1:0]         ref_base;

	assign valid_eff = clear ? '0 : valid_q;
	assign pages     = page_q;
	assign bound     = rank_eff[idx];

	always_comb begin
		for (int i = 0; i < NUM_FRAMES; i++)
			rank_eff[i] = clear ? '0 : rank_q[i];
	end

	always_comb begin
		for (int i = 0; i < NUM_FRAMES; i++) begin
			valid_nx[i] = valid_eff[i];
			rank_nx[i]  = rank_eff[i];
			if (IDX_W'(i) == idx) begin
				rank_nx[i] = '0;
				if (look.fill)
					valid_nx[i] = 1'b1;
			end else if (active[i] && valid_eff[i] && rank_eff[i] != RANK_MAX
				&& (!look.hit || rank_eff[i] < bound)) begin
				rank_nx[i] = rank_eff[i] + 1'b1;
			end
		end
	end

	always_comb begin
		fault_base = clear ? '0 : fault_q;
		ref_base   = clear ? '0 : ref_q;
		ref_nx     = ref_base;
		fault_nx   = fault_base;
		if (ref_base != lru_pr_pkg::CNT_MAX)
			ref_nx = ref_base + 1'b1;
		if (!look.hit && fault_base != lru_pr_pkg::CNT_MAX)
			fault_nx = fault_base + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rank_q  <= '0;
			fault_q <= '0;
			ref_q   <= '0;
		end else if (upd) begin
			valid_q <= valid_nx;
			rank_q  <= rank_nx;
			fault_q <= fault_nx;
			ref_q   <= ref_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (upd && !look.hit)
			page_q[idx] <= page;
	end

endmodule
`default_nettype wire

[src/lru_page_replacement.sv]
// Path: a reference is held in the input register and its result in the
// result register, which holds the result until the sink takes it.
// Throughput: one reference per cycle while rsp.ready does not stall the result
// register; tag compare, victim pick and rank update for all frames complete
// combinationally between the input register and the result register.
// Reset (arst_n low, asynchronous): all frames empty, ranks and counters
// zero, frame limit 16, no result pending.
`default_nettype none
module lru_page_replacement #(
	parameter int NUM_FRAMES = 16,
	parameter int PAGE_BITS  = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [lru_pr_pkg::CFG_W-1:0]  cfg_wdata,
	lru_pr_req_if.sink                         req,
	lru_pr_rsp_if.source                       rsp
);

	localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int EXT_W = IDX_W + lru_pr_pkg::SLOT_W;

	logic [lru_pr_pkg::CFG_W-1:0]     cfg_q;

	logic                             valid_s1;
	logic                             clear_s1;
	logic [PAGE_BITS-1:0]             page_s1;

	logic                             valid_s2;
	logic                             hit_s2;
	logic [lru_pr_pkg::SLOT_W-1:0]    slot_s2;
	logic                             ev_valid_s2;
	logic [PAGE_BITS-1:0]             ev_page_s2;
	logic [lru_pr_pkg::CNT_W-1:0]     fault_s2;
	logic [lru_pr_pkg::CNT_W-1:0]     ref_s2;

	logic                             adv;
	logic [NUM_FRAMES-1:0]            active;
	logic [NUM_FRAMES-1:0]            valid_eff;
	logic [NUM_FRAMES-1:0][IDX_W-1:0] rank_eff;
	logic [NUM_FRAMES-1:0][PAGE_BITS-1:0] pages;
	lru_pr_pkg::lookup_t              look;
	logic [IDX_W-1:0]                 idx;
	logic [EXT_W-1:0]                 idx_ext;
	logic [lru_pr_pkg::CNT_W-1:0]     fault_nx;
	logic [lru_pr_pkg::CNT_W-1:0]     ref_nx;

	assign adv       = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv;
	assign idx_ext   = EXT_W'(idx);

	// frame 0 is always active; limits above the frame count clamp naturally
	for (genvar gi = 0; gi < NUM_FRAMES; gi++) begin : g_active
		if (gi == 0) begin : g_first
			assign active[gi] = 1'b1;
		end else if (gi < 32) begin : g_cmp
			localparam logic [lru_pr_pkg::CFG_W-1:0] IC = lru_pr_pkg::CFG_W'(gi);
			assign active[gi] = IC < cfg_q;
		end else begin : g_off
			assign active[gi] = 1'b0;
		end
	end

	lru_pr_select #(
		.NUM_FRAMES (NUM_FRAMES),
		.PAGE_BITS  (PAGE_BITS),
		.IDX_W      (IDX_W)
	) u_select (
		.valid_eff (valid_eff),
		.active    (active),
		.pages     (pages),
		.rank_eff  (rank_eff),
		.page      (page_s1),
		.look      (look),
		.idx       (idx)
	);

	lru_pr_frames #(
		.NUM_FRAMES (NUM_FRAMES),
		.PAGE_BITS  (PAGE_BITS),
		.IDX_W      (IDX_W)
	) u_frames (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (adv),
		.clear     (clear_s1),
		.page      (page_s1),
		.active    (active),
		.look      (look),
		.idx       (idx),
		.valid_eff (valid_eff),
		.rank_eff  (rank_eff),
		.pages     (pages),
		.fault_nx  (fault_nx),
		.ref_nx    (ref_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q    <= lru_pr_pkg::FRAMES_RESET;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cfg_we)
				cfg_q <= cfg_wdata;
			if (req.ready)
				valid_s1 <= req.valid;
			if (adv)
				valid_s2 <= 1'b1;
			else if (rsp.ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			clear_s1 <= req.clear_first;
			page_s1  <= req.page;
		end
		if (adv) begin
			hit_s2      <= look.hit;
			slot_s2     <= idx_ext[lru_pr_pkg::SLOT_W-1:0];
			ev_valid_s2 <= look.evict;
			ev_page_s2  <= look.evict ? pages[idx] : '0;
			fault_s2    <= fault_nx;
			ref_s2      <= ref_nx;
		end
	end

	assign rsp.valid           = valid_s2;
	assign rsp.hit             = hit_s2;
	assign rsp.slot            = slot_s2;
	assign rsp.evicted_valid   = ev_valid_s2;
	assign rsp.evicted_page    = ev_page_s2;
	assign rsp.fault_count     = fault_s2;
	assign rsp.reference_count = ref_s2;

	a_adv_fills_out : assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("result register not loaded after advance");

	a_clear_counts : assert property (@(posedge clk) disable iff (!arst_n)
		adv && clear_s1 |=> (ref_s2 == 32'd1) && (fault_s2 == 32'd1) && !hit_s2)
		else $error("reference after clear not counted as first fault");

	a_evict_full : assert property (@(posedge clk) disable iff (!arst_n)
		adv && look.evict |-> ((valid_eff | ~active) == {NUM_FRAMES{1'b1}}))
		else $error("eviction while a free active frame exists");

endmodule
`default_nettype wire

[tb/testbench.sv]
module testbench;

	localparam int NFR         = 16;
	localparam int PAGE_W      = 16;
	localparam int STALL_LIMIT = 2000;

	localparam int SLOT_W = lru_pr_pkg::SLOT_W;
	localparam int CNT_W  = lru_pr_pkg::CNT_W;
	localparam int CFG_W  = lru_pr_pkg::CFG_W;
	localparam logic [CNT_W-1:0] CNT_MAX      = lru_pr_pkg::CNT_MAX;
	localparam logic [CFG_W-1:0] FRAMES_RESET = lru_pr_pkg::FRAMES_RESET;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic              evicted;
		logic [PAGE_W-1:0] victim_page;
		logic [CNT_W-1:0]  faults;
		logic [CNT_W-1:0]  refs;
	} page_outcome_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	lru_pr_req_if #(.PAGE_BITS(PAGE_W)) req_ch ();
	lru_pr_rsp_if #(.PAGE_BITS(PAGE_W)) rsp_ch ();

	lru_page_replacement #(
		.NUM_FRAMES(NFR),
		.PAGE_BITS (PAGE_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	logic [PAGE_W-1:0] held_page [NFR];
	bit                held_valid [NFR];
	logic [SLOT_W-1:0] age_rank [NFR];
	logic [CNT_W-1:0]  fault_total;
	logic [CNT_W-1:0]  ref_total;
	logic [CFG_W-1:0]  frame_limit;

	page_outcome_t outcome_queue [$];
	int            error_count;
	int            quiet_cycles;
	bit            src_steady;
	bit            sink_steady;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int active_frames();
		if (frame_limit == '0)
			return 1;
		if (frame_limit > NFR)
			return NFR;
		return int'(frame_limit);
	endfunction

	function automatic void age_frames(int f, int lim, logic [SLOT_W-1:0] bound, bit all);
		for (int i = 0; i < lim; i++) begin
			if (i != f && held_valid[i] && (all || age_rank[i] < bound)) begin
				if (age_rank[i] < SLOT_W'(NFR - 1))
					age_rank[i] = age_rank[i] + 1'b1;
			end
		end
		age_rank[f] = '0;
	endfunction

	function automatic page_outcome_t predict_reference(logic clr, logic [PAGE_W-1:0] pg);
		page_outcome_t     res;
		int                lim;
		int                f;
		bit                found;
		logic [SLOT_W-1:0] oldest;

		res = '0;
		lim = active_frames();
		f = 0;
		found = 0;
		if (clr) begin
			for (int i = 0; i < NFR; i++) begin
				held_valid[i] = 0;
				held_page[i] = '0;
				age_rank[i] = '0;
			end
			fault_total = '0;
			ref_total = '0;
		end
		if (ref_total != CNT_MAX)
			ref_total = ref_total + 1;
		for (int i = 0; i < lim && !found; i++) begin
			if (held_valid[i] && held_page[i] == pg) begin
				found = 1;
				f = i;
			end
		end
		if (found) begin
			res.hit = 1'b1;
			age_frames(f, lim, age_rank[f], 0);
		end else begin
			if (fault_total != CNT_MAX)
				fault_total = fault_total + 1;
			for (int i = 0; i < lim && !found; i++) begin
				if (!held_valid[i]) begin
					found = 1;
					f = i;
				end
			end
			if (!found) begin
				oldest = '0;
				f = 0;
				for (int i = 0; i < lim; i++) begin
					if (age_rank[i] > oldest) begin
						oldest = age_rank[i];
						f = i;
					end
				end
				res.evicted = 1'b1;
				res.victim_page = held_page[f];
			end
			held_valid[f] = 1;
			held_page[f] = pg;
			age_frames(f, lim, '0, 1);
		end
		res.slot = SLOT_W'(f);
		res.faults = fault_total;
		res.refs = ref_total;
		return res;
	endfunction

	task automatic send_reference(input logic clr, input logic [PAGE_W-1:0] pg);
		int gap;

		gap = src_steady ? 0 : $urandom_range(0, 8);
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.clear_first = clr;
		req_ch.page = pg;
		do @(posedge clk); while (!req_ch.ready);
		outcome_queue.insert(outcome_queue.size(), predict_reference(clr, pg));
	endtask

	task automatic settle_idle();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (outcome_queue.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_frame_limit(input logic [CFG_W-1:0] value);
		settle_idle();
		cfg_we = 1'b1;
		cfg_wdata = value;
		frame_limit = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic compare_field(input string fname, input logic [CNT_W-1:0] want,
			input logic [CNT_W-1:0] got);
		if (want !== got) begin
			error_count++;
			$display("%0t %s mismatch: expected %0h, actual %0h", $time, fname, want, got);
		end
	endtask

	task automatic check_outcome();
		page_outcome_t want;

		if (outcome_queue.size() == 0) begin
			error_count++;
			$display("%0t unexpected transaction: expected none, actual page slot %0d",
				$time, rsp_ch.slot);
		end else begin
			want = outcome_queue[0];
			outcome_queue.delete(0);
			compare_field("hit", CNT_W'(want.hit), CNT_W'(rsp_ch.hit));
			compare_field("slot", CNT_W'(want.slot), CNT_W'(rsp_ch.slot));
			compare_field("evicted_valid", CNT_W'(want.evicted),
				CNT_W'(rsp_ch.evicted_valid));
			compare_field("evicted_page", CNT_W'(want.victim_page),
				CNT_W'(rsp_ch.evicted_page));
			compare_field("fault_count", want.faults, rsp_ch.fault_count);
			compare_field("reference_count", want.refs, rsp_ch.reference_count);
		end
	endtask

	initial begin
		int stall;

		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = sink_steady ? 0 : $urandom_range(0, 8);
			@(negedge clk);
			if (stall > 0) begin
				rsp_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready = 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			check_outcome();
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic test_fill_and_evict();
		send_reference(1'b1, 16'h0000);
		send_reference(1'b0, 16'hFFFF);
		send_reference(1'b0, 16'h0000);
		write_frame_limit(5'd4);
		send_reference(1'b1, 16'hAAAA);
		send_reference(1'b0, 16'h5555);
		send_reference(1'b0, 16'h1234);
		send_reference(1'b0, 16'hFFFF);
		send_reference(1'b0, 16'h5555);
		send_reference(1'b0, 16'h8000);
		send_reference(1'b0, 16'h0001);
	endtask

	task automatic test_frame_count_limits();
		write_frame_limit(5'd0);
		send_reference(1'b0, 16'h0F0F);
		send_reference(1'b0, 16'hF0F0);
		send_reference(1'b0, 16'hF0F0);
		write_frame_limit(5'd31);
		send_reference(1'b0, 16'h0001);
		send_reference(1'b0, 16'h0002);
	endtask

	task automatic test_shrink_mid_trace();
		write_frame_limit(FRAMES_RESET);
		send_reference(1'b1, 16'h0100);
		send_reference(1'b0, 16'h0101);
		send_reference(1'b0, 16'h0102);
		send_reference(1'b0, 16'h0103);
		send_reference(1'b0, 16'h0104);
		write_frame_limit(5'd3);
		send_reference(1'b0, 16'h0104);
		send_reference(1'b0, 16'h0200);
		write_frame_limit(FRAMES_RESET);
		send_reference(1'b0, 16'h0104);
		send_reference(1'b0, 16'h0103);
		send_reference(1'b0, 16'h0300);
	endtask

	task automatic test_random_traces();
		int                limits [10] = '{16, 1, 2, 5, 8, 31, 0, 17, 12, 16};
		int                lim;
		int                pool;
		logic [CFG_W-1:0]  value;
		logic [PAGE_W-1:0] base;
		logic [PAGE_W-1:0] pg;
		logic              clr;

		for (int p = 0; p < 10; p++) begin
			value = (p == 8) ? CFG_W'($urandom_range(0, 31)) : CFG_W'(limits[p]);
			write_frame_limit(value);
			lim = active_frames();
			pool = lim + $urandom_range(0, 4);
			base = PAGE_W'($urandom);
			for (int i = 0; i < 43; i++) begin
				if (i % 21 == 0) begin
					src_steady = ($urandom_range(0, 3) == 0);
					sink_steady = ($urandom_range(0, 3) == 0);
				end
				clr = (i == 0 && p % 2 == 0) || ($urandom_range(0, 31) == 0);
				if ($urandom_range(0, 99) < 85)
					pg = base + PAGE_W'($urandom_range(0, pool - 1));
				else
					pg = PAGE_W'($urandom);
				send_reference(clr, pg);
			end
		end
		src_steady = 0;
		sink_steady = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.clear_first = 1'b0;
		req_ch.page = '0;
		error_count = 0;
		quiet_cycles = 0;
		src_steady = 0;
		sink_steady = 0;
		frame_limit = FRAMES_RESET;
		fault_total = '0;
		ref_total = '0;
		for (int i = 0; i < NFR; i++) begin
			held_valid[i] = 0;
			held_page[i] = '0;
			age_rank[i] = '0;
		end
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_fill_and_evict();
		test_frame_count_limits();
		test_shrink_mid_trace();
		test_random_traces();

		settle_idle();
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

[sim.f]
src/lru_pr_pkg.sv
src/lru_pr_req_if.sv
src/lru_pr_rsp_if.sv
src/lru_pr_select.sv
src/lru_pr_frames.sv
src/lru_page_replacement.sv
tb/testbench.sv
